@@ sv/bsfr_pkg.sv @@
// Shared types, codes and constants of the byte-stuffing frame receiver.
package bsfr_pkg;

    localparam int COUNTER_WIDTH_DEFAULT = 32;

    localparam int PAYLOAD_LEN = 6;
    localparam int CNT_NUM     = 7;

    localparam logic [7:0] HDR_BYTE = 8'hAA;
    localparam logic [7:0] ESC_BYTE = 8'hAB;
    localparam logic [7:0] ESC_HDR  = 8'h01;
    localparam logic [7:0] ESC_ESC  = 8'h02;

    // request commands
    localparam logic [2:0] CMD_RECV  = 3'd0;
    localparam logic [2:0] CMD_TICK  = 3'd1;
    localparam logic [2:0] CMD_TAKE  = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    // statistics counter indexes
    localparam logic [2:0] CNT_BYTES   = 3'd0;
    localparam logic [2:0] CNT_DROP    = 3'd1;
    localparam logic [2:0] CNT_CHK     = 3'd2;
    localparam logic [2:0] CNT_RANGE   = 3'd3;
    localparam logic [2:0] CNT_TIMEOUT = 3'd4;
    localparam logic [2:0] CNT_ESC     = 3'd5;
    localparam logic [2:0] CNT_GOOD    = 3'd6;

    // frame status codes
    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_NO_DATA = 2'd1;
    localparam logic [1:0] ST_CHK     = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SOC_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_TEMP_LIMIT = 2'd1;
    localparam logic [1:0] CFG_RPM_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

    localparam logic [7:0]  SOC_LIMIT_RST  = 8'd100;
    localparam logic [7:0]  TEMP_LIMIT_RST = 8'd60;
    localparam logic [15:0] RPM_LIMIT_RST  = 16'd10000;
    localparam logic [31:0] TIMEOUT_RST    = 32'd100;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_ESC     = 2'd2
    } t_rx_mode;

endpackage

@@ sv/byte_stuffing_frame_receiver.sv @@
// Byte-stuffing frame receiver: deframer, checksum/range check and statistics.
// Usage:
//   Requests enter on i_valid/o_stall with i_cmd and its operands: receive a
//   line byte, a millisecond tick, take the held frame, read a statistics
//   counter or clear all counters. Every request yields exactly one result on
//   o_valid/i_stall carrying the frame status, the decoded telemetry fields,
//   the selected counter value, the frame-pending flag and the decoder mode.
//   Configuration (limits, partial frame timeout) is written on the separate
//   i_cfg_valid/o_cfg_ready port, which is always ready; write it only while
//   no request is in flight.
// Timing:
//   A request is captured in an input register, processed by one short layer
//   of logic (five-byte XOR, three limit compares, 32-bit elapsed-time compare)
//   and its result lands in the output register; one request per cycle is
//   sustained while i_stall stays low.
// Stall:
//   While i_stall holds a pending result, the next request advances into the
//   input register and then o_stall rises; nothing is lost or reordered.
// Reset:
//   i_rst_n low (synchronous) empties both registers, returns the decoder to
//   idle, drops any held frame, clears counters and loads reset limits.
module byte_stuffing_frame_receiver #(
    parameter int COUNTER_WIDTH = bsfr_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_current_time,
    input  logic [2:0]  i_counter_select,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_speed,
    output logic [7:0]  o_soc,
    output logic [7:0]  o_pack_temp,
    output logic [15:0] o_drive_rpm,
    output logic        o_frame_pending,
    output logic [31:0] o_counter_value,
    output logic [1:0]  o_decoder_mode,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int PLEN = bsfr_pkg::PAYLOAD_LEN;
    localparam int CNUM = bsfr_pkg::CNT_NUM;
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};

    // configuration registers
    logic [7:0]  r_soc_limit;
    logic [7:0]  r_temp_limit;
    logic [15:0] r_rpm_limit;
    logic [31:0] r_timeout;

    // input register
    logic        r_in_valid;
    logic [2:0]  r_in_cmd;
    logic [7:0]  r_in_byte;
    logic [31:0] r_in_time;
    logic [2:0]  r_in_sel;

    // decoder state
    bsfr_pkg::t_rx_mode r_mode, n_mode;
    logic [2:0]  r_count, n_count;
    logic [7:0]  r_partial [PLEN];
    logic [7:0]  n_partial [PLEN];
    logic [7:0]  r_held [PLEN];
    logic [7:0]  n_held [PLEN];
    logic        r_frame_held, n_frame_held;
    logic [31:0] r_last_time, n_last_time;
    logic [COUNTER_WIDTH-1:0] r_cnt [CNUM];
    logic [COUNTER_WIDTH-1:0] n_cnt [CNUM];

    // result register
    logic        r_out_valid;
    logic [1:0]  r_status, n_status;
    logic [7:0]  r_speed, n_speed;
    logic [7:0]  r_soc, n_soc;
    logic [7:0]  r_temp, n_temp;
    logic [15:0] r_rpm, n_rpm;
    logic        r_ready_flag, n_ready_flag;
    logic [31:0] r_cval, n_cval;
    logic [1:0]  r_mode_out, n_mode_out;

    // working signals
    logic        advance;
    logic        w_store;
    logic [7:0]  w_store_byte;
    logic [7:0]  w_chk;
    logic [31:0] w_elapsed;
    logic [15:0] w_rpm;
    logic [31:0] w_cnt_low;

    // Move the captured request into the result register when that register
    // is empty or its result is being taken this cycle.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    assign o_valid         = r_out_valid;
    assign o_frame_status  = r_status;
    assign o_speed         = r_speed;
    assign o_soc           = r_soc;
    assign o_pack_temp     = r_temp;
    assign o_drive_rpm     = r_rpm;
    assign o_frame_pending = r_ready_flag;
    assign o_counter_value = r_cval;
    assign o_decoder_mode  = r_mode_out;

    // Configuration writes; indexes past the list have no register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soc_limit  <= bsfr_pkg::SOC_LIMIT_RST;
            r_temp_limit <= bsfr_pkg::TEMP_LIMIT_RST;
            r_rpm_limit  <= bsfr_pkg::RPM_LIMIT_RST;
            r_timeout    <= bsfr_pkg::TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bsfr_pkg::CFG_SOC_LIMIT:  r_soc_limit  <= i_cfg_data[7:0];
                bsfr_pkg::CFG_TEMP_LIMIT: r_temp_limit <= i_cfg_data[7:0];
                bsfr_pkg::CFG_RPM_LIMIT:  r_rpm_limit  <= i_cfg_data[15:0];
                bsfr_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: capture a request whenever the slot is free or draining.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_cmd  <= i_cmd;
            r_in_byte <= i_data_byte;
            r_in_time <= i_current_time;
            r_in_sel  <= i_counter_select;
        end
    end

    // Control state: mode, fill count, held flag, time reference, counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= bsfr_pkg::MODE_IDLE;
            r_count      <= '0;
            r_frame_held <= 1'b0;
            r_last_time  <= '0;
            for (int i = 0; i < CNUM; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (advance) begin
            r_mode       <= n_mode;
            r_count      <= n_count;
            r_frame_held <= n_frame_held;
            r_last_time  <= n_last_time;
            for (int i = 0; i < CNUM; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    // Payload bytes: valid only once written, guarded by the fill count and
    // the held flag, so no reset.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < PLEN; i++) begin
                r_partial[i] <= n_partial[i];
                r_held[i]    <= n_held[i];
            end
        end
    end

    // Result register: hold while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status     <= n_status;
            r_speed      <= n_speed;
            r_soc        <= n_soc;
            r_temp       <= n_temp;
            r_rpm        <= n_rpm;
            r_ready_flag <= n_ready_flag;
            r_cval       <= n_cval;
            r_mode_out   <= n_mode_out;
        end
    end

    // Frame checksum over held bytes 0..4, header included.
    always_comb begin
        w_chk = bsfr_pkg::HDR_BYTE;
        for (int i = 0; i < PLEN - 1; i++) begin
            w_chk = w_chk ^ r_held[i];
        end
    end

    assign w_elapsed = r_in_time - r_last_time;
    assign w_rpm     = {r_held[3], r_held[4]};
    assign w_cnt_low = 32'(r_cnt[r_in_sel]);

    // Next state and result for the captured request.
    always_comb begin
        n_mode       = r_mode;
        n_count      = r_count;
        n_frame_held = r_frame_held;
        n_last_time  = r_last_time;
        for (int i = 0; i < CNUM; i++) begin
            n_cnt[i] = r_cnt[i];
        end
        for (int i = 0; i < PLEN; i++) begin
            n_partial[i] = r_partial[i];
            n_held[i]    = r_held[i];
        end
        n_status     = bsfr_pkg::ST_VALID;
        n_speed      = '0;
        n_soc        = '0;
        n_temp       = '0;
        n_rpm        = '0;
        n_cval       = '0;
        w_store      = 1'b0;
        w_store_byte = r_in_byte;

        unique case (r_in_cmd)
            bsfr_pkg::CMD_RECV: begin
                n_cnt[bsfr_pkg::CNT_BYTES] = r_cnt[bsfr_pkg::CNT_BYTES] + CNT_ONE;
                unique case (r_mode)
                    bsfr_pkg::MODE_IDLE: begin
                        if (r_in_byte == bsfr_pkg::HDR_BYTE) begin
                            n_count = '0;
                            n_mode  = bsfr_pkg::MODE_PAYLOAD;
                        end
                    end
                    bsfr_pkg::MODE_PAYLOAD: begin
                        if (r_in_byte == bsfr_pkg::HDR_BYTE) begin
                            n_count = '0;
                        end else if (r_in_byte == bsfr_pkg::ESC_BYTE) begin
                            n_mode = bsfr_pkg::MODE_ESC;
                        end else begin
                            w_store = 1'b1;
                        end
                    end
                    bsfr_pkg::MODE_ESC: begin
                        if (r_in_byte == bsfr_pkg::ESC_HDR ||
                            r_in_byte == bsfr_pkg::ESC_ESC) begin
                            n_mode       = bsfr_pkg::MODE_PAYLOAD;
                            w_store      = 1'b1;
                            w_store_byte = (r_in_byte == bsfr_pkg::ESC_HDR) ?
                                           bsfr_pkg::HDR_BYTE : bsfr_pkg::ESC_BYTE;
                        end else begin
                            // stuffing error: drop the frame
                            n_cnt[bsfr_pkg::CNT_ESC] = r_cnt[bsfr_pkg::CNT_ESC] + CNT_ONE;
                            n_mode = bsfr_pkg::MODE_IDLE;
                        end
                    end
                    default: n_mode = bsfr_pkg::MODE_IDLE;
                endcase

                if (w_store && (r_count < 3'(PLEN))) begin
                    n_partial[r_count] = w_store_byte;
                    n_count            = r_count + 3'd1;
                    if (r_count == 3'(PLEN - 1)) begin
                        // last payload byte: hold the frame or count a drop
                        if (!r_frame_held) begin
                            for (int i = 0; i < PLEN - 1; i++) begin
                                n_held[i] = r_partial[i];
                            end
                            n_held[PLEN-1] = w_store_byte;
                            n_frame_held   = 1'b1;
                        end else begin
                            n_cnt[bsfr_pkg::CNT_DROP] = r_cnt[bsfr_pkg::CNT_DROP] + CNT_ONE;
                        end
                        n_mode = bsfr_pkg::MODE_IDLE;
                    end
                end
            end
            bsfr_pkg::CMD_TICK: begin
                if (r_mode == bsfr_pkg::MODE_IDLE) begin
                    n_last_time = r_in_time;
                end else if (w_elapsed >= r_timeout) begin
                    // abandon the partial frame and restart the time reference
                    n_mode      = bsfr_pkg::MODE_IDLE;
                    n_count     = '0;
                    n_last_time = r_in_time;
                    n_cnt[bsfr_pkg::CNT_TIMEOUT] = r_cnt[bsfr_pkg::CNT_TIMEOUT] + CNT_ONE;
                end
            end
            bsfr_pkg::CMD_TAKE: begin
                if (!r_frame_held) begin
                    n_status = bsfr_pkg::ST_NO_DATA;
                end else begin
                    n_frame_held = 1'b0;
                    if (w_chk != r_held[PLEN-1]) begin
                        n_cnt[bsfr_pkg::CNT_CHK] = r_cnt[bsfr_pkg::CNT_CHK] + CNT_ONE;
                        n_status = bsfr_pkg::ST_CHK;
                    end else begin
                        n_speed = r_held[0];
                        n_soc   = r_held[1];
                        n_temp  = r_held[2];
                        n_rpm   = w_rpm;
                        if (r_held[1] > r_soc_limit || r_held[2] > r_temp_limit ||
                            w_rpm > r_rpm_limit) begin
                            n_cnt[bsfr_pkg::CNT_RANGE] = r_cnt[bsfr_pkg::CNT_RANGE] + CNT_ONE;
                            n_status = bsfr_pkg::ST_RANGE;
                        end else begin
                            n_cnt[bsfr_pkg::CNT_GOOD] = r_cnt[bsfr_pkg::CNT_GOOD] + CNT_ONE;
                            n_status = bsfr_pkg::ST_VALID;
                        end
                    end
                end
            end
            bsfr_pkg::CMD_READ: begin
                if (r_in_sel < 3'(CNUM)) begin
                    n_cval = w_cnt_low;
                end
            end
            bsfr_pkg::CMD_CLEAR: begin
                for (int i = 0; i < CNUM; i++) begin
                    n_cnt[i] = '0;
                end
            end
            default: ;
        endcase

        n_ready_flag = n_frame_held;
        n_mode_out   = n_mode;
    end

endmodule

@@ tb/sv/tb_byte_stuffing_frame_receiver.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the byte-stuffing frame receiver.
module tb_byte_stuffing_frame_receiver;

    // Commands the block decodes as no-ops, and the counter select that reads zero.
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [2:0] SEL_NONE     = 3'd7;

    // Six payload bytes; byte 0 is speed, byte 5 the checksum.
    typedef logic [bsfr_pkg::PAYLOAD_LEN-1:0][7:0] t_frame_word;

    // One decoded result as the block should present it.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  speed;
        logic [7:0]  soc;
        logic [7:0]  temp;
        logic [15:0] rpm;
        logic        ready;
        logic [31:0] count;
        logic [1:0]  mode;
    } t_telemetry;

    // ------------------------------------------------------------------
    // Block ports; every input is known from time zero.
    // ------------------------------------------------------------------
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [2:0]  i_cmd            = bsfr_pkg::CMD_RECV;
    logic [7:0]  i_data_byte      = 8'h00;
    logic [31:0] i_current_time   = 32'h0;
    logic [2:0]  i_counter_select = bsfr_pkg::CNT_BYTES;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [1:0]  o_frame_status;
    logic [7:0]  o_speed;
    logic [7:0]  o_soc;
    logic [7:0]  o_pack_temp;
    logic [15:0] o_drive_rpm;
    logic        o_frame_pending;
    logic [31:0] o_counter_value;
    logic [1:0]  o_decoder_mode;
    logic        i_cfg_valid      = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index      = bsfr_pkg::CFG_SOC_LIMIT;
    logic [31:0] i_cfg_data       = 32'h0;

    byte_stuffing_frame_receiver uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .i_current_time   (i_current_time),
        .i_counter_select (i_counter_select),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_status   (o_frame_status),
        .o_speed          (o_speed),
        .o_soc            (o_soc),
        .o_pack_temp      (o_pack_temp),
        .o_drive_rpm      (o_drive_rpm),
        .o_frame_pending  (o_frame_pending),
        .o_counter_value  (o_counter_value),
        .o_decoder_mode   (o_decoder_mode),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the deframer: limits, decoder state, held frame,
    // statistics. Updated once per accepted request.
    // ------------------------------------------------------------------
    logic [7:0]  lim_soc;
    logic [7:0]  lim_temp;
    logic [15:0] lim_rpm;
    logic [31:0] lim_timeout;
    bsfr_pkg::t_rx_mode rx_state;
    logic [2:0]  fill;
    t_frame_word partial_bytes;
    t_frame_word held_bytes;
    logic        frame_waiting;
    logic [31:0] idle_ref_ms;
    logic [31:0] stat_count [bsfr_pkg::CNT_NUM];

    t_telemetry  expected_results [$];
    t_telemetry  oldest_result;

    // Run bookkeeping.
    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int take_tally [4]  = '{0, 0, 0, 0};

    // Idling controls for both sides, plus the long receiver hold-off.
    bit request_gaps_on = 1'b1;
    bit result_gaps_on  = 1'b1;
    bit hold_request    = 1'b0;
    int hold_left       = 0;
    int stall_burst     = 0;

    // XOR of the header with payload bytes 0..4.
    function automatic logic [7:0] frame_checksum(input t_frame_word f);
        logic [7:0] sum;
        sum = bsfr_pkg::HDR_BYTE;
        for (int i = 0; i < bsfr_pkg::PAYLOAD_LEN - 1; i++) sum ^= f[i];
        return sum;
    endfunction

    // Append one decoded payload byte; on the sixth, hold the frame or count a drop.
    function automatic void store_payload_byte(input logic [7:0] b);
        if (fill < bsfr_pkg::PAYLOAD_LEN) begin
            partial_bytes[fill] = b;
            fill++;
        end
        if (fill >= bsfr_pkg::PAYLOAD_LEN) begin
            if (!frame_waiting) begin
                held_bytes    = partial_bytes;
                frame_waiting = 1'b1;
            end else begin
                stat_count[bsfr_pkg::CNT_DROP]++;
            end
            rx_state = bsfr_pkg::MODE_IDLE;
        end
    endfunction

    // Advance the shadow state by one request and queue the result it must produce.
    function automatic void predict_request(input logic [2:0] cmd, input logic [7:0] data,
                                            input logic [31:0] now_ms, input logic [2:0] sel);
        t_telemetry want;
        logic [7:0] sum;
        want = '0;
        case (cmd)
            bsfr_pkg::CMD_RECV: begin
                // Every line byte counts, whatever the decoder does with it.
                stat_count[bsfr_pkg::CNT_BYTES]++;
                case (rx_state)
                    bsfr_pkg::MODE_IDLE: begin
                        if (data == bsfr_pkg::HDR_BYTE) begin
                            fill     = '0;
                            rx_state = bsfr_pkg::MODE_PAYLOAD;
                        end
                    end
                    bsfr_pkg::MODE_PAYLOAD: begin
                        if (data == bsfr_pkg::HDR_BYTE) fill = '0;
                        else if (data == bsfr_pkg::ESC_BYTE) rx_state = bsfr_pkg::MODE_ESC;
                        else store_payload_byte(data);
                    end
                    default: begin
                        // After an escape only the two stuffing codes are legal;
                        // a header here is a stuffing error too.
                        if (data == bsfr_pkg::ESC_HDR || data == bsfr_pkg::ESC_ESC) begin
                            rx_state = bsfr_pkg::MODE_PAYLOAD;
                            store_payload_byte(data == bsfr_pkg::ESC_HDR ?
                                               bsfr_pkg::HDR_BYTE : bsfr_pkg::ESC_BYTE);
                        end else begin
                            stat_count[bsfr_pkg::CNT_ESC]++;
                            rx_state = bsfr_pkg::MODE_IDLE;
                        end
                    end
                endcase
            end
            bsfr_pkg::CMD_TICK: begin
                // Idle ticks and firing ticks move the reference; others leave it.
                if (rx_state == bsfr_pkg::MODE_IDLE) begin
                    idle_ref_ms = now_ms;
                end else if (32'(now_ms - idle_ref_ms) >= lim_timeout) begin
                    rx_state    = bsfr_pkg::MODE_IDLE;
                    fill        = '0;
                    idle_ref_ms = now_ms;
                    stat_count[bsfr_pkg::CNT_TIMEOUT]++;
                end
            end
            bsfr_pkg::CMD_TAKE: begin
                if (!frame_waiting) begin
                    want.status = bsfr_pkg::ST_NO_DATA;
                end else begin
                    sum           = frame_checksum(held_bytes);
                    frame_waiting = 1'b0;
                    if (sum != held_bytes[bsfr_pkg::PAYLOAD_LEN-1]) begin
                        stat_count[bsfr_pkg::CNT_CHK]++;
                        want.status = bsfr_pkg::ST_CHK;
                    end else begin
                        want.speed = held_bytes[0];
                        want.soc   = held_bytes[1];
                        want.temp  = held_bytes[2];
                        want.rpm   = {held_bytes[3], held_bytes[4]};
                        if (want.soc > lim_soc || want.temp > lim_temp ||
                            want.rpm > lim_rpm) begin
                            stat_count[bsfr_pkg::CNT_RANGE]++;
                            want.status = bsfr_pkg::ST_RANGE;
                        end else begin
                            stat_count[bsfr_pkg::CNT_GOOD]++;
                            want.status = bsfr_pkg::ST_VALID;
                        end
                    end
                end
                take_tally[want.status]++;
            end
            bsfr_pkg::CMD_READ: begin
                if (sel < bsfr_pkg::CNT_NUM) want.count = stat_count[sel];
            end
            bsfr_pkg::CMD_CLEAR: begin
                foreach (stat_count[i]) stat_count[i] = '0;
            end
            default: ;
        endcase
        want.ready = frame_waiting;
        want.mode  = rx_state;
        expected_results.push_back(want);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, status %0h counter %0h", $time,
                         o_frame_status, o_counter_value);
            end else begin
                oldest_result = expected_results.pop_front();
                check_field("frame_status", 32'(oldest_result.status),
                            32'(o_frame_status));
                check_field("speed", 32'(oldest_result.speed), 32'(o_speed));
                check_field("soc", 32'(oldest_result.soc), 32'(o_soc));
                check_field("pack_temp", 32'(oldest_result.temp), 32'(o_pack_temp));
                check_field("drive_rpm", 32'(oldest_result.rpm), 32'(o_drive_rpm));
                check_field("frame_pending", 32'(oldest_result.ready),
                            32'(o_frame_pending));
                check_field("counter_value", oldest_result.count, o_counter_value);
                check_field("decoder_mode", 32'(oldest_result.mode),
                            32'(o_decoder_mode));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: a requested long hold-off wins, else random stall bursts
    // while result gaps are enabled.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = 120;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (stall_burst > 0) begin
            i_stall = 1'b1;
            stall_burst--;
        end else if (result_gaps_on && $urandom_range(0, 5) == 0) begin
            stall_burst = $urandom_range(1, 13) - 1;
            i_stall     = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Request driver. Enter and leave at a falling edge; hold the payload
    // until the block accepts it, then predict its result.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [2:0] cmd, input logic [7:0] data,
                                input logic [31:0] now_ms, input logic [2:0] sel);
        int gap;
        if (request_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_cmd            = cmd;
        i_data_byte      = data;
        i_current_time   = now_ms;
        i_counter_select = sel;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(cmd, data, now_ms, sel);
        items_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Line byte; the unused operands carry random bits.
    task automatic send_byte(input logic [7:0] b);
        send_request(bsfr_pkg::CMD_RECV, b, $urandom, 3'($urandom_range(0, 7)));
    endtask

    // Command without a line byte or time; the unused operands carry random bits.
    task automatic send_command(input logic [2:0] cmd, input logic [2:0] sel);
        send_request(cmd, 8'($urandom), $urandom, sel);
    endtask

    // Escape header and escape bytes on the line.
    task automatic send_stuffed(input logic [7:0] b);
        if (b == bsfr_pkg::HDR_BYTE) begin
            send_byte(bsfr_pkg::ESC_BYTE);
            send_byte(bsfr_pkg::ESC_HDR);
        end else if (b == bsfr_pkg::ESC_BYTE) begin
            send_byte(bsfr_pkg::ESC_BYTE);
            send_byte(bsfr_pkg::ESC_ESC);
        end else begin
            send_byte(b);
        end
    endtask

    task automatic send_frame(input t_frame_word f);
        send_byte(bsfr_pkg::HDR_BYTE);
        for (int i = 0; i < bsfr_pkg::PAYLOAD_LEN; i++) send_stuffed(f[i]);
    endtask

    // Tick whose elapsed time lands near zero, at the timeout edges, or anywhere.
    task automatic send_tick();
        logic [31:0] delta;
        case ($urandom_range(0, 3))
            0, 1:    delta = $urandom_range(0, 150);
            2:       delta = lim_timeout + $urandom_range(0, 2) - 1;
            default: delta = $urandom;
        endcase
        send_request(bsfr_pkg::CMD_TICK, 8'($urandom), idle_ref_ms + delta,
                     3'($urandom_range(0, 7)));
    endtask

    // Value mostly within the limit, sometimes on or just past it, or anywhere up to top.
    function automatic int unsigned pick_value(input int unsigned limit, input int unsigned top);
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, top);
            1:       return limit;
            2:       return (limit == top) ? 0 : limit + 1;
            default: return $urandom_range(0, limit);
        endcase
    endfunction

    // Random telemetry frame; sprinkle header and escape values into the payload; flip a checksum bit unless good_sum.
    task automatic build_frame(output t_frame_word f, input bit good_sum);
        int unsigned rpm_val;
        f[0]    = 8'($urandom);
        f[1]    = 8'(pick_value(lim_soc, 255));
        f[2]    = 8'(pick_value(lim_temp, 255));
        rpm_val = pick_value(lim_rpm, 65535);
        f[3]    = rpm_val[15:8];
        f[4]    = rpm_val[7:0];
        for (int i = 0; i < bsfr_pkg::PAYLOAD_LEN - 1; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                f[i] = $urandom_range(0, 1) ? bsfr_pkg::HDR_BYTE : bsfr_pkg::ESC_BYTE;
            end
        end
        f[5] = frame_checksum(f);
        if (!good_sum) f[5] = f[5] ^ (8'd1 << $urandom_range(0, 7));
    endtask

    // Wait until every expected result is in, then let the pipeline settle.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        while (expected_results.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            expected_results.delete();
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            bsfr_pkg::CFG_SOC_LIMIT:  lim_soc     = value[7:0];
            bsfr_pkg::CFG_TEMP_LIMIT: lim_temp    = value[7:0];
            bsfr_pkg::CFG_RPM_LIMIT:  lim_rpm     = value[15:0];
            default:                  lim_timeout = value;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drain, then load all four limits; junk in the unused upper bits must be ignored.
    task automatic apply_limits(input logic [7:0] soc, input logic [7:0] temp,
                                input logic [15:0] rpm, input logic [31:0] timeout_ms);
        logic [31:0] junk;
        junk = $urandom;
        wait_for_results();
        write_register(bsfr_pkg::CFG_SOC_LIMIT,  {junk[31:8], soc});
        write_register(bsfr_pkg::CFG_TEMP_LIMIT, {junk[23:0], temp});
        write_register(bsfr_pkg::CFG_RPM_LIMIT,  {junk[15:0], rpm});
        write_register(bsfr_pkg::CFG_TIMEOUT,    timeout_ms);
    endtask

    // Mixed traffic: half complete frames with random content, the rest
    // takes, ticks, counter reads and clears, broken frames and raw noise.
    task automatic run_traffic(input int quota);
        int          stop_at;
        int          choice;
        int          k;
        t_frame_word f;
        logic [7:0]  bad;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            choice = $urandom_range(0, 99);
            if (choice < 50) begin
                build_frame(f, $urandom_range(0, 4) != 0);
                send_frame(f);
                if ($urandom_range(0, 9) < 7) begin
                    send_command(bsfr_pkg::CMD_TAKE, 3'($urandom_range(0, 7)));
                end
            end else if (choice < 60) begin
                send_command(bsfr_pkg::CMD_TAKE, 3'($urandom_range(0, 7)));
            end else if (choice < 68) begin
                send_tick();
            end else if (choice < 75) begin
                send_command(bsfr_pkg::CMD_READ, 3'($urandom_range(0, 7)));
            end else if (choice < 77) begin
                send_command(bsfr_pkg::CMD_CLEAR, 3'($urandom_range(0, 7)));
            end else if (choice < 90) begin
                // Start a frame, cut it short, then break, abandon or restart it.
                send_byte(bsfr_pkg::HDR_BYTE);
                k = $urandom_range(0, 5);
                repeat (k) send_stuffed(8'($urandom));
                case ($urandom_range(0, 2))
                    0: begin
                        bad = 8'($urandom);
                        if (bad == bsfr_pkg::ESC_HDR || bad == bsfr_pkg::ESC_ESC) begin
                            bad = bsfr_pkg::HDR_BYTE;
                        end
                        send_byte(bsfr_pkg::ESC_BYTE);
                        send_byte(bad);
                    end
                    1: send_tick();
                    default: begin
                        build_frame(f, 1'b1);
                        send_frame(f);
                    end
                endcase
            end else begin
                send_request(3'($urandom_range(0, 7)), 8'($urandom), $urandom,
                             3'($urandom_range(0, 7)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner cases at reset limits: empty take, spare commands and select,
    // stuffed frame out of range, header after escape, timeout edge, counters.
    task automatic test_directed();
        t_frame_word f;
        send_command(bsfr_pkg::CMD_TAKE, bsfr_pkg::CNT_BYTES);
        send_command(bsfr_pkg::CMD_READ, SEL_NONE);
        send_request(CMD_SPARE_HI, 8'hFF, 32'hFFFF_FFFF, SEL_NONE);
        send_request(CMD_SPARE_LO, 8'h00, 32'h0, bsfr_pkg::CNT_BYTES);
        // Speed and soc need stuffing; soc and rpm break their limits.
        f[0] = bsfr_pkg::HDR_BYTE;
        f[1] = bsfr_pkg::ESC_BYTE;
        f[2] = 8'h00;
        f[3] = 8'hFF;
        f[4] = 8'hFF;
        f[5] = frame_checksum(f);
        send_frame(f);
        send_command(bsfr_pkg::CMD_TAKE, bsfr_pkg::CNT_GOOD);
        // Header right after an escape is a stuffing error.
        send_byte(bsfr_pkg::HDR_BYTE);
        send_byte(bsfr_pkg::ESC_BYTE);
        send_byte(bsfr_pkg::HDR_BYTE);
        // Idle tick sets the reference; fire exactly at the timeout, not one before.
        send_request(bsfr_pkg::CMD_TICK, 8'h00, 32'd5, bsfr_pkg::CNT_BYTES);
        send_byte(bsfr_pkg::HDR_BYTE);
        send_request(bsfr_pkg::CMD_TICK, 8'h00, 32'd5 + lim_timeout - 1,
                     bsfr_pkg::CNT_BYTES);
        send_request(bsfr_pkg::CMD_TICK, 8'h00, 32'd5 + lim_timeout, bsfr_pkg::CNT_BYTES);
        send_command(bsfr_pkg::CMD_READ, bsfr_pkg::CNT_ESC);
        send_command(bsfr_pkg::CMD_READ, bsfr_pkg::CNT_TIMEOUT);
        send_command(bsfr_pkg::CMD_READ, bsfr_pkg::CNT_BYTES);
        send_command(bsfr_pkg::CMD_CLEAR, bsfr_pkg::CNT_BYTES);
        send_command(bsfr_pkg::CMD_READ, bsfr_pkg::CNT_BYTES);
    endtask

    // Zero limits, full-scale limits, then a random set.
    task automatic test_register_extremes();
        apply_limits(8'd0, 8'd0, 16'd0, 32'd0);
        run_traffic(120);
        apply_limits(8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        run_traffic(120);
        apply_limits(8'($urandom), 8'($urandom), 16'($urandom), $urandom_range(1, 300));
        run_traffic(120);
    endtask

    // Bulk traffic at near-default limits, idling switched per chunk.
    task automatic test_random_traffic();
        apply_limits(bsfr_pkg::SOC_LIMIT_RST, bsfr_pkg::TEMP_LIMIT_RST,
                     bsfr_pkg::RPM_LIMIT_RST, 32'd40);
        repeat (4) begin
            request_gaps_on = 1'($urandom_range(0, 1));
            result_gaps_on  = 1'($urandom_range(0, 1));
            run_traffic(200);
        end
        request_gaps_on = 1'b1;
        result_gaps_on  = 1'b1;
    endtask

    // Hold off the result side while requests keep coming, so the block fills
    // and stalls its input.
    task automatic test_backpressure();
        wait_for_results();
        request_gaps_on = 1'b0;
        result_gaps_on  = 1'b0;
        hold_request    = 1'b1;
        run_traffic(40);
        wait_for_results();
        request_gaps_on = 1'b1;
        result_gaps_on  = 1'b1;
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_steady_stream();
        request_gaps_on = 1'b0;
        result_gaps_on  = 1'b0;
        run_traffic(250);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        lim_soc       = bsfr_pkg::SOC_LIMIT_RST;
        lim_temp      = bsfr_pkg::TEMP_LIMIT_RST;
        lim_rpm       = bsfr_pkg::RPM_LIMIT_RST;
        lim_timeout   = bsfr_pkg::TIMEOUT_RST;
        rx_state      = bsfr_pkg::MODE_IDLE;
        fill          = '0;
        partial_bytes = '0;
        held_bytes    = '0;
        frame_waiting = 1'b0;
        idle_ref_ms   = '0;
        foreach (stat_count[i]) stat_count[i] = '0;

        // Hold reset from time zero, release it at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();
        wait_for_results();

        $display("Sent %0d requests under several limit settings, checked %0d results.",
                 items_sent, results_checked);
        $display("Takes: %0d valid, %0d empty, %0d bad checksum, %0d out of range.",
                 take_tally[bsfr_pkg::ST_VALID], take_tally[bsfr_pkg::ST_NO_DATA],
                 take_tally[bsfr_pkg::ST_CHK], take_tally[bsfr_pkg::ST_RANGE]);
        if (error_count == 0) begin
            $display("tb_byte_stuffing_frame_receiver: clean");
        end else begin
            $display("tb_byte_stuffing_frame_receiver: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("tb_byte_stuffing_frame_receiver: errors");
        $finish;
    end

endmodule

@@ files.f @@
sv/bsfr_pkg.sv
sv/byte_stuffing_frame_receiver.sv
tb/sv/tb_byte_stuffing_frame_receiver.sv
